// File: hdl/cti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_pkg: shared types and constants of the compare timer
// Command and result codes, beat structs and the prescaler divider table.
// ----------------------------------------------------------------------------
package cti_pkg;

   // widest supported channel count; masks in beats are this wide
   localparam int MAX_CHANNELS = 4;
   localparam int PRESCALE_BITS = 10;
   localparam int CSR_INDEX_BITS = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESCALE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLED = 1'b1;

   typedef enum logic [2:0] {
      CMD_TICK         = 3'd0,
      CMD_SET_ABS      = 3'd1,
      CMD_SET_REL      = 3'd2,
      CMD_SET_PERIODIC = 3'd3,
      CMD_CLEAR        = 3'd4,
      CMD_READ         = 3'd5,
      CMD_STOP         = 3'd6,
      CMD_START        = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_READ   = 2'd1,
      KIND_MATCH  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK               = 2'd0,
      ST_NOT_ENABLED      = 2'd1,
      ST_PERIODIC_REFUSED = 2'd2
   } status_type;

   // one input beat as held in the input register
   typedef struct packed {
      cmd_type     command;
      logic [1:0]  channel;
      logic [15:0] value;
   } item_type;

   // result set of one item: a status, a read, or a group of match events
   typedef struct packed {
      kind_type                kind;
      status_type              status;
      logic [15:0]             count;
      logic [MAX_CHANNELS-1:0] mask;
   } rdesc_type;

   // prescaler terminal count, 2^exp - 1 for exp in 0,1,2,3,6,8,10
   function automatic logic [PRESCALE_BITS-1:0] prescale_limit(input logic [2:0] sel);
      logic [PRESCALE_BITS-1:0] lim;
      begin
         case (sel)
            3'd0: lim = 10'd0;
            3'd1: lim = 10'd1;
            3'd2: lim = 10'd3;
            3'd3: lim = 10'd7;
            3'd4: lim = 10'd63;
            3'd5: lim = 10'd255;
            default: lim = 10'd1023;  // index six and above: divide by 1024
         endcase
         return lim;
      end
   endfunction

   // index of the lowest set bit
   function automatic logic [1:0] lowest_index(input logic [MAX_CHANNELS-1:0] mask);
      logic [1:0] idx;
      begin
         idx = 2'd0;
         for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
            if (mask[i]) idx = 2'(i);
         end
         return idx;
      end
   endfunction

endpackage

// File: hdl/cti_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_core: timer state and command execution
// Holds counter, prescaler, compare channels and configuration; executes one
// item per cycle while the result slot is free; results go to the output stage.
// ----------------------------------------------------------------------------
module cti_core import cti_pkg::*; #(
   parameter int NUM_CHANNELS = 4,
   parameter int COUNT_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_go,
   input  item_type                  item,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [2:0]                csr_data,
   output logic                      desc_load,
   output rdesc_type                 desc
);

   logic [2:0]               prescale_sel_ff, prescale_sel_in;
   logic [2:0]               enabled_ff, enabled_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [PRESCALE_BITS-1:0] pcount_ff, pcount_in;
   logic [COUNT_BITS-1:0]    cmp_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]    cmp_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]  armed_ff, armed_in;
   logic [NUM_CHANNELS-1:0]  oneshot_ff, oneshot_in;
   logic                     periodic_ff, periodic_in;
   logic                     running_ff, running_in;

   logic [2:0]               usable;
   logic                     chan_ok;
   logic [COUNT_BITS-1:0]    count_inc;
   logic [COUNT_BITS-1:0]    value_cb;
   logic [NUM_CHANNELS-1:0]  hit;
   logic [PRESCALE_BITS-1:0] limit;

   // channels usable by commands, capped at the built channel count
   assign usable = (enabled_ff > 3'(NUM_CHANNELS)) ? 3'(NUM_CHANNELS) : enabled_ff;
   assign chan_ok = ({1'b0, item.channel} < usable);
   assign count_inc = COUNT_BITS'(count_ff + 1'b1);
   assign value_cb = COUNT_BITS'(item.value);
   assign limit = prescale_limit(prescale_sel_ff);

   // compare lanes against the incremented count
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         hit[c] = armed_ff[c] && (cmp_ff[c] == count_inc);
      end
   end

   // command execution
   always_comb begin
      prescale_sel_in = prescale_sel_ff;
      enabled_in = enabled_ff;
      count_in = count_ff;
      pcount_in = pcount_ff;
      cmp_in = cmp_ff;
      armed_in = armed_ff;
      oneshot_in = oneshot_ff;
      periodic_in = periodic_ff;
      running_in = running_ff;
      desc_load = 1'b0;
      desc.kind = KIND_STATUS;
      desc.status = ST_OK;
      desc.count = '0;
      desc.mask = '0;

      if (csr_write) begin
         case (csr_index)
            CSR_PRESCALE: prescale_sel_in = csr_data;
            CSR_ENABLED: enabled_in = csr_data;
            default: ;
         endcase
      end

      if (item_go) begin
         case (item.command)
            CMD_TICK: begin
               if (running_ff) begin
                  if (pcount_ff >= limit) begin
                     pcount_in = '0;
                     count_in = count_inc;
                     armed_in = armed_ff & ~(hit & oneshot_ff);
                     if (periodic_ff && (count_inc == cmp_ff[0])) count_in = '0;
                     if (|hit) begin
                        desc_load = 1'b1;
                        desc.kind = KIND_MATCH;
                        desc.mask = MAX_CHANNELS'(hit);
                     end
                  end else begin
                     pcount_in = PRESCALE_BITS'(pcount_ff + 1'b1);
                  end
               end
            end
            CMD_SET_ABS, CMD_SET_REL: begin
               desc_load = 1'b1;
               if (!chan_ok) begin
                  desc.status = ST_NOT_ENABLED;
               end else begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (item.channel == 2'(c)) begin
                        cmp_in[c] = (item.command == CMD_SET_ABS) ? value_cb
                                  : COUNT_BITS'(count_ff + value_cb);
                        oneshot_in[c] = 1'b1;
                        armed_in[c] = 1'b1;
                     end
                  end
               end
            end
            CMD_SET_PERIODIC: begin
               desc_load = 1'b1;
               if ((item.channel != 2'd0) || (usable != 3'd1)) begin
                  desc.status = ST_PERIODIC_REFUSED;
               end else begin
                  count_in = '0;
                  pcount_in = '0;
                  cmp_in[0] = value_cb;
                  armed_in = NUM_CHANNELS'(1);
                  oneshot_in[0] = 1'b0;
                  periodic_in = 1'b1;
                  running_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               desc_load = 1'b1;
               if (!chan_ok) begin
                  desc.status = ST_NOT_ENABLED;
               end else begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (item.channel == 2'(c)) armed_in[c] = 1'b0;
                  end
               end
            end
            CMD_READ: begin
               desc_load = 1'b1;
               desc.kind = KIND_READ;
               desc.count = 16'(count_ff);
            end
            CMD_STOP: begin
               desc_load = 1'b1;
               running_in = 1'b0;
               count_in = '0;
               pcount_in = '0;
            end
            CMD_START: begin
               desc_load = 1'b1;
               running_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_sel_ff <= 3'd0;
         enabled_ff <= 3'd4;
         count_ff <= '0;
         pcount_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) cmp_ff[c] <= '0;
         armed_ff <= '0;
         oneshot_ff <= '0;
         periodic_ff <= 1'b0;
         running_ff <= 1'b1;
      end else begin
         prescale_sel_ff <= prescale_sel_in;
         enabled_ff <= enabled_in;
         count_ff <= count_in;
         pcount_ff <= pcount_in;
         cmp_ff <= cmp_in;
         armed_ff <= armed_in;
         oneshot_ff <= oneshot_in;
         periodic_ff <= periodic_in;
         running_ff <= running_in;
      end
   end

   // a one-shot channel that matched is disarmed afterwards
   a_oneshot_disarm: assert property (@(posedge clock) disable iff (reset)
      desc_load && (desc.kind == KIND_MATCH) |=>
         (armed_ff & $past(desc.mask[NUM_CHANNELS-1:0] & oneshot_ff)) == '0)
      else $error("one-shot channel still armed after match");

   // match events only come from armed channels
   a_match_armed: assert property (@(posedge clock) disable iff (reset)
      desc_load && (desc.kind == KIND_MATCH) |->
         (desc.mask[NUM_CHANNELS-1:0] & ~armed_ff) == '0)
      else $error("match event from disarmed channel");

endmodule

// File: hdl/cti_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_emit: result register and beat serializer
// Holds one result set and sends it as beats, one match event per beat in
// ascending channel order.
// ----------------------------------------------------------------------------
module cti_emit import cti_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       desc_load,
   input  rdesc_type  desc,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_event_channel,
   output logic [15:0] rsp_count_value,
   output logic       rsp_last
);

   logic                    desc_valid_ff, desc_valid_in;
   rdesc_type               desc_ff, desc_in;
   logic                    is_match;
   logic [MAX_CHANNELS-1:0] rest_mask;
   logic                    beat;
   logic                    done;

   // beat fields from the held result set
   assign is_match = (desc_ff.kind == KIND_MATCH);
   assign rest_mask = desc_ff.mask & (desc_ff.mask - 1'b1);
   assign rsp_valid = desc_valid_ff;
   assign rsp_kind = desc_ff.kind;
   assign rsp_status = desc_ff.status;
   assign rsp_count_value = desc_ff.count;
   assign rsp_event_channel = is_match ? lowest_index(desc_ff.mask) : 2'd0;
   assign rsp_last = !is_match || (rest_mask == '0);

   assign beat = rsp_valid && !rsp_stall;
   assign done = beat && rsp_last;
   assign slot_free = !desc_valid_ff || done;

   // load a new set, or drop the event just sent
   always_comb begin
      desc_valid_in = desc_valid_ff;
      desc_in = desc_ff;
      if (desc_load) begin
         desc_valid_in = 1'b1;
         desc_in = desc;
      end else if (done) begin
         desc_valid_in = 1'b0;
      end else if (beat) begin
         desc_in.mask = rest_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   // a held match set always has an event left
   a_match_nonempty: assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff && is_match |-> desc_ff.mask != '0)
      else $error("empty match set held");

   // no set is overwritten before its last beat leaves
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      desc_load |-> slot_free)
      else $error("result set overwritten");

   // each non-final beat removes exactly one event
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      beat && !rsp_last |=> desc_valid_ff &&
         ($countones(desc_ff.mask) + 1 == $countones($past(desc_ff.mask))))
      else $error("event lost or repeated");

endmodule

// File: hdl/compare_timer_oneshot_periodic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compare_timer_oneshot_periodic: timer counter with compare channels
// Prescaled up counter with one-shot and periodic compare channels, driven
// by tick and command beats; results leave as status, read or match beats.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, channel, value
//   rsp      out        rsp_valid/rsp_stall  kind, status, event_channel,
//                                            count_value, last
//   csr      in         csr_write            csr_index, csr_data
//
// One beat per cycle in unless stalled; results pass the input and result registers.
// A tick that matches k channels occupies the result register for k beats and
// holds the input until the last leaves; other commands take one, a quiet tick none.
// Reset is synchronous; the timer comes up running with all channels idle.
// rsp_stall backs up into the result register, then the one-beat input
// register, then req_stall.
// ----------------------------------------------------------------------------
module compare_timer_oneshot_periodic import cti_pkg::*; #(
   parameter int NUM_CHANNELS = 4,
   parameter int COUNT_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_command,
   input  logic [1:0]                req_channel,
   input  logic [15:0]               req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [1:0]                rsp_status,
   output logic [1:0]                rsp_event_channel,
   output logic [15:0]               rsp_count_value,
   output logic                      rsp_last,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [2:0]                csr_data
);

   logic      in_valid_ff, in_valid_in;
   item_type  in_item_ff, in_item_in;
   logic      slot_free;
   logic      item_go;
   logic      req_beat;
   logic      desc_load;
   rdesc_type desc;

   // input register: taken when empty or when its item moves on
   assign item_go = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;
   assign req_beat = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
         in_item_in.command = cmd_type'(req_command);
         in_item_in.channel = req_channel;
         in_item_in.value = req_value;
      end else if (item_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   cti_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_go   (item_go),
      .item      (in_item_ff),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .desc_load (desc_load),
      .desc      (desc)
   );

   cti_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .desc_load         (desc_load),
      .desc              (desc),
      .slot_free         (slot_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_event_channel (rsp_event_channel),
      .rsp_count_value   (rsp_count_value),
      .rsp_last          (rsp_last)
   );

endmodule

// File: sim/tb_compare_timer_oneshot_periodic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compare_timer_oneshot_periodic: self-checking bench for the compare timer
// Drives command and tick beats with random gaps and response back-pressure,
// predicts every status, read and match beat in a scoreboard and compares
// them in order. Runs directed corner cases, then random traffic under
// several prescaler and channel-count settings, ending in periodic mode.
// ----------------------------------------------------------------------------
package timer_sb_pkg;
   import cti_pkg::*;

   // one expected result beat
   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [1:0]  chan;
      logic [15:0] count_value;
      logic        last;
   } timer_result_type;

   class timer_scoreboard;
      timer_result_type pending_results[$];

      // register copies
      logic [2:0]  prescale_sel;
      logic [2:0]  enabled_cnt;

      // timer state
      logic [15:0] counter_val;
      logic [9:0]  prescale_cnt;
      logic [15:0] compare_val [4];
      logic [3:0]  armed;
      logic [3:0]  oneshot;
      bit          periodic;
      bit          running;

      int unsigned items_seen;
      int unsigned beats_checked;
      int unsigned match_beats;
      int unsigned read_beats;
      int unsigned status_beats;
      int unsigned mismatches;

      function new();
         prescale_sel = 3'd0;
         enabled_cnt = 3'd4;
         counter_val = 16'd0;
         prescale_cnt = 10'd0;
         foreach (compare_val[i]) compare_val[i] = 16'd0;
         armed = 4'd0;
         oneshot = 4'd0;
         periodic = 1'b0;
         running = 1'b1;
         items_seen = 0;
         beats_checked = 0;
         match_beats = 0;
         read_beats = 0;
         status_beats = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [2:0] data);
         if (idx == CSR_PRESCALE) begin
            prescale_sel = data;
         end else begin
            enabled_cnt = data;
         end
      endfunction

      // channel count that commands may address
      function int unsigned usable();
         return (enabled_cnt > 3'd4) ? 4 : int'(enabled_cnt);
      endfunction

      function void push_beat(kind_type k, status_type s, logic [1:0] ch,
                              logic [15:0] cnt, logic lst);
         timer_result_type b;
         b.kind = k;
         b.status = s;
         b.chan = ch;
         b.count_value = cnt;
         b.last = lst;
         pending_results.push_back(b);
      endfunction

      // one tick command: prescaler, counter, compare channels
      function void advance_tick();
         int unsigned shift;
         logic [9:0]  limit;
         logic [3:0]  hit;
         int          last_ch;
         if (!running) return;
         case (prescale_sel)
            3'd0: shift = 0;
            3'd1: shift = 1;
            3'd2: shift = 2;
            3'd3: shift = 3;
            3'd4: shift = 6;
            3'd5: shift = 8;
            default: shift = 10;
         endcase
         limit = 10'((1 << shift) - 1);
         if (prescale_cnt < limit) begin
            prescale_cnt = prescale_cnt + 10'd1;
            return;
         end
         prescale_cnt = 10'd0;
         counter_val = counter_val + 16'd1;
         hit = 4'd0;
         for (int c = 0; c < 4; c++) begin
            if (armed[c] && compare_val[c] == counter_val) begin
               hit[c] = 1'b1;
               if (oneshot[c]) armed[c] = 1'b0;
            end
         end
         // periodic wrap happens even with channel 0 disarmed
         if (periodic && counter_val == compare_val[0]) counter_val = 16'd0;
         last_ch = -1;
         for (int c = 0; c < 4; c++) begin
            if (hit[c]) last_ch = c;
         end
         for (int c = 0; c < 4; c++) begin
            if (hit[c]) push_beat(KIND_MATCH, ST_OK, 2'(c), 16'd0, c == last_ch);
         end
      endfunction

      // expected beats of one accepted command beat
      function void predict_command(cmd_type cmd, logic [1:0] ch, logic [15:0] val);
         status_type st;
         st = ST_OK;
         items_seen++;
         case (cmd)
            CMD_TICK: begin
               advance_tick();
               return;
            end
            CMD_SET_ABS, CMD_SET_REL: begin
               if (ch >= usable()) begin
                  st = ST_NOT_ENABLED;
               end else begin
                  compare_val[ch] = (cmd == CMD_SET_ABS) ? val : counter_val + val;
                  oneshot[ch] = 1'b1;
                  armed[ch] = 1'b1;
               end
            end
            CMD_SET_PERIODIC: begin
               if (ch != 2'd0 || usable() != 1) begin
                  st = ST_PERIODIC_REFUSED;
               end else begin
                  counter_val = 16'd0;
                  prescale_cnt = 10'd0;
                  compare_val[0] = val;
                  armed = 4'b0001;
                  oneshot[0] = 1'b0;
                  periodic = 1'b1;
                  running = 1'b1;
               end
            end
            CMD_CLEAR: begin
               if (ch >= usable()) begin
                  st = ST_NOT_ENABLED;
               end else begin
                  armed[ch] = 1'b0;
               end
            end
            CMD_READ: begin
               push_beat(KIND_READ, ST_OK, 2'd0, counter_val, 1'b1);
               return;
            end
            CMD_STOP: begin
               running = 1'b0;
               counter_val = 16'd0;
               prescale_cnt = 10'd0;
            end
            default: running = 1'b1;
         endcase
         push_beat(KIND_STATUS, st, 2'd0, 16'd0, 1'b1);
      endfunction

      // compare one accepted result beat against the oldest expectation
      function void check_beat(logic [1:0] kind, logic [1:0] status, logic [1:0] ch,
                               logic [15:0] cnt, logic lst);
         timer_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected beat kind %0d status %0d chan %0d count %h last %0d",
                        $time, kind, status, ch, cnt, lst);
            return;
         end
         want = pending_results.pop_front();
         beats_checked++;
         case (want.kind)
            KIND_MATCH: match_beats++;
            KIND_READ: read_beats++;
            default: status_beats++;
         endcase
         if (kind !== want.kind || status !== want.status || ch !== want.chan ||
             cnt !== want.count_value || lst !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: beat %0d expected kind %0d status %0d chan %0d count %h last %0d",
                        $time, beats_checked, want.kind, want.status, want.chan,
                        want.count_value, want.last);
               $display("%0t: beat %0d got      kind %0d status %0d chan %0d count %h last %0d",
                        $time, beats_checked, kind, status, ch, cnt, lst);
            end
         end
      endfunction
   endclass
endpackage

module tb_compare_timer_oneshot_periodic;
   import cti_pkg::*;
   import timer_sb_pkg::*;

   localparam int CLK_HALF     = 2;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 12;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_command = 3'd0;
   logic [1:0]                req_channel = 2'd0;
   logic [15:0]               req_value = 16'd0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_kind;
   logic [1:0]                rsp_status;
   logic [1:0]                rsp_event_channel;
   logic [15:0]               rsp_count_value;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [2:0]                csr_data = 3'd0;

   timer_scoreboard sb;

   // traffic shaping flags
   bit          quiet = 1'b0;
   bit          burst = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_pick;
   int unsigned settings_used = 0;

   // free-running phase settings: prescale select, enabled channels
   int unsigned prescale_plan [8] = '{0, 7, 1, 0, 2, 0, 3, 5};
   int unsigned enabled_plan [8]  = '{4, 2, 6, 4, 0, 1, 3, 7};
   int unsigned periodic_pres [3] = '{0, 0, 1};
   int unsigned periodic_en [3]   = '{1, 4, 1};

   compare_timer_oneshot_periodic dut (.*);

   always #(CLK_HALF) clock = ~clock;

   // result side: check every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat(rsp_kind, rsp_status, rsp_event_channel, rsp_count_value, rsp_last);
   end

   // result side back-pressure, including one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_req && !hold_done) begin
         rsp_stall = 1'b1;
         hold_left++;
         if (hold_left == HOLD_CYCLES) hold_done = 1'b1;
      end else if (quiet) begin
         rsp_stall = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall = 1'b0;
         end else if (stall_pick < 95) begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(7, 30);
         end
      end
   end

   // sender gap before a beat: mostly none, some short, a few long
   task automatic idle_gap();
      int unsigned r;
      int unsigned n;
      if (quiet || burst) return;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // offer one command beat and hold it until accepted
   task automatic send_item(cmd_type cmd, logic [1:0] ch, logic [15:0] val);
      idle_gap();
      req_valid = 1'b1;
      req_command = cmd;
      req_channel = ch;
      req_value = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_command(cmd, ch, val);
      @(negedge clock);
   endtask

   // all expected beats in, then let silent ticks drain
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [2:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_timer_config(int unsigned pres, int unsigned en);
      wait_idle();
      write_csr(CSR_PRESCALE, 3'(pres));
      write_csr(CSR_ENABLED, 3'(en));
      settings_used++;
   endtask

   task automatic tick_n(int unsigned n);
      repeat (n) send_item(CMD_TICK, 2'(0), 16'($urandom));
   endtask

   // random beat; mostly ticks and near-term compares so matches fire
   task automatic random_item(bit periodic_ok);
      int unsigned r;
      cmd_type     cmd;
      logic [1:0]  ch;
      logic [15:0] val;
      r = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      val = 16'($urandom);
      if (r < 52) begin
         cmd = CMD_TICK;
      end else if (r < 64) begin
         cmd = CMD_SET_REL;
         if ($urandom_range(0, 3) != 0) val = 16'($urandom_range(1, 12));
      end else if (r < 72) begin
         cmd = CMD_SET_ABS;
         if (periodic_ok) val = 16'($urandom_range(0, 15));
         else if ($urandom_range(0, 1) != 0)
            val = sb.counter_val + 16'($urandom_range(1, 12));
      end else if (r < 77) begin
         cmd = CMD_SET_PERIODIC;
         if (periodic_ok) begin
            if ($urandom_range(0, 4) != 0) ch = 2'd0;
            val = 16'($urandom_range(1, 12));
         end else if (sb.usable() == 1 && ch == 2'd0) begin
            // keep the free-running phases out of periodic mode
            ch = 2'($urandom_range(1, 3));
         end
      end else if (r < 84) begin
         cmd = CMD_CLEAR;
      end else if (r < 91) begin
         cmd = CMD_READ;
      end else if (r < 95) begin
         cmd = CMD_STOP;
      end else begin
         cmd = CMD_START;
      end
      send_item(cmd, ch, val);
   endtask

   // run watchdog
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      sb = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // all four channels on one count, wrap of a relative compare, stop/start
      set_timer_config(0, 4);
      send_item(CMD_READ, 2'd0, 16'h0000);
      send_item(CMD_SET_ABS, 2'd0, 16'h0002);
      send_item(CMD_SET_ABS, 2'd1, 16'h0002);
      send_item(CMD_SET_ABS, 2'd2, 16'h0002);
      send_item(CMD_SET_ABS, 2'd3, 16'h0002);
      tick_n(2);
      send_item(CMD_SET_REL, 2'd1, 16'hFFFF);
      send_item(CMD_SET_PERIODIC, 2'd0, 16'h0007);
      send_item(CMD_START, 2'd3, 16'hFFFF);
      send_item(CMD_STOP, 2'd2, 16'h0000);
      tick_n(1);
      send_item(CMD_START, 2'd0, 16'h0000);
      send_item(CMD_SET_ABS, 2'd0, 16'hFFFF);
      send_item(CMD_CLEAR, 2'd3, 16'h0000);
      send_item(CMD_READ, 2'd3, 16'hFFFF);

      // out-of-range divider and no enabled channels; prescaler part way
      set_timer_config(7, 0);
      send_item(CMD_SET_ABS, 2'd0, 16'h5555);
      send_item(CMD_SET_PERIODIC, 2'd0, 16'hAAAA);
      send_item(CMD_CLEAR, 2'd0, 16'h0000);
      tick_n(4);

      // shorter divider: next tick completes the period; enabled above max
      set_timer_config(0, 7);
      tick_n(1);
      send_item(CMD_READ, 2'd0, 16'h0000);

      // free-running random phases
      for (int p = 0; p < 8; p++) begin
         if (p == 7) set_timer_config($urandom_range(0, 6), $urandom_range(0, 7));
         else set_timer_config(prescale_plan[p], enabled_plan[p]);
         quiet = (p == 0 || p == 5);
         if (p == 3) begin
            hold_req = 1'b1;
            burst = 1'b1;
         end
         repeat (24) random_item(1'b0);
         quiet = 1'b0;
         burst = 1'b0;
      end

      // channel armed earlier still matches with fewer channels enabled
      set_timer_config(0, 4);
      send_item(CMD_START, 2'd0, 16'h0000);
      send_item(CMD_SET_REL, 2'd2, 16'h0003);
      set_timer_config(0, 1);
      tick_n(3);
      send_item(CMD_SET_ABS, 2'd1, 16'h8000);
      send_item(CMD_CLEAR, 2'd2, 16'h0000);
      send_item(CMD_SET_PERIODIC, 2'd1, 16'h0005);
      send_item(CMD_SET_PERIODIC, 2'd0, 16'h0002);
      tick_n(3);
      // one-shot compare in periodic mode; wrap continues once disarmed
      send_item(CMD_SET_ABS, 2'd0, 16'h0001);
      tick_n(3);
      send_item(CMD_READ, 2'd0, 16'h0000);

      // periodic random phases
      for (int p = 0; p < 3; p++) begin
         set_timer_config(periodic_pres[p], periodic_en[p]);
         repeat (25) random_item(1'b1);
      end

      wait_idle();
      $display("Ran %0d command beats over %0d register settings, one-shot and periodic,",
               sb.items_seen, settings_used);
      $display("with a %0d-cycle result hold; checked %0d beats",
               HOLD_CYCLES, sb.beats_checked);
      $display("(%0d match, %0d read, %0d status).",
               sb.match_beats, sb.read_beats, sb.status_beats);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
